// ===== hdl/heading_quaternion_from_motion_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the heading quaternion block
// shared property templates, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef HEADING_QUATERNION_FROM_MOTION_ASSERT_SVH
`define HEADING_QUATERNION_FROM_MOTION_ASSERT_SVH

// same-cycle implication
`define HQFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hqfm: same-cycle check failed");

// next-cycle implication
`define HQFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hqfm: next-cycle check failed");

`endif

// ===== hdl/hqfm_pkg.sv =====
// ----------------------------------------------------------------------------
// hqfm_pkg
// shared constants, types and the arctangent table of the heading block
// ----------------------------------------------------------------------------
package hqfm_pkg;

  // position format and cordic depth
  localparam int POS_FRAC_BITS = 8;
  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_LEN      = 24;
  localparam int STEPS         = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int ITER_W        = $clog2(ATAN_LEN);

  // cordic datapath width, covers negation and gain growth of 32-bit inputs
  localparam int CW = 36;

  // configuration port
  localparam int PADDR_W = 3;
  localparam logic REG_IDX_MOVE_THR = 1'b0;
  localparam logic [31:0] THR_RESET =
    32'(((64'd1 << (2 * POS_FRAC_BITS)) + 64'd5) / 64'd10);

  // cordic constants
  localparam logic signed [CW-1:0] INV_GAIN  = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] ANGLE_PI  = CW'(64'sd2147483648);
  localparam logic signed [15:0]   Q15_ONE   = 16'sd32767;
  localparam logic signed [15:0]   Q15_ZERO  = 16'sd0;

  // heading source codes
  typedef enum logic [1:0] {
    SRC_FIRST = 2'd0,
    SRC_NEW   = 2'd1,
    SRC_HELD  = 2'd2
  } hqfm_src_e;

  // result of the cordic unit
  typedef struct packed {
    logic               done;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } hqfm_cordic_res_t;

  // rounded arctangent of 2^-i, 2^32 per full turn
  function automatic logic signed [CW-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:    v = CW'(64'sd536870912);
      5'd1:    v = CW'(64'sd316933406);
      5'd2:    v = CW'(64'sd167458907);
      5'd3:    v = CW'(64'sd85004756);
      5'd4:    v = CW'(64'sd42667331);
      5'd5:    v = CW'(64'sd21354465);
      5'd6:    v = CW'(64'sd10679838);
      5'd7:    v = CW'(64'sd5340245);
      5'd8:    v = CW'(64'sd2670163);
      5'd9:    v = CW'(64'sd1335087);
      5'd10:   v = CW'(64'sd667544);
      5'd11:   v = CW'(64'sd333772);
      5'd12:   v = CW'(64'sd166886);
      5'd13:   v = CW'(64'sd83443);
      5'd14:   v = CW'(64'sd41722);
      5'd15:   v = CW'(64'sd20861);
      5'd16:   v = CW'(64'sd10430);
      5'd17:   v = CW'(64'sd5215);
      5'd18:   v = CW'(64'sd2608);
      5'd19:   v = CW'(64'sd1304);
      5'd20:   v = CW'(64'sd652);
      5'd21:   v = CW'(64'sd326);
      5'd22:   v = CW'(64'sd163);
      5'd23:   v = CW'(64'sd81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/heading_quaternion_from_motion.sv =====
// ----------------------------------------------------------------------------
// heading_quaternion_from_motion
// sequence: a first fix gives the identity quaternion; a later fix squares
//   dx and dy in turn on the shared squaring multiplier, compares the sum
//   with the threshold, then runs the shared cordic micro-rotation unit for
//   a new heading or holds the old one; the input stalls until the push
// reset: asynchronous active low, identity quaternion, first fix pending,
//   threshold back to its default
// ----------------------------------------------------------------------------
module heading_quaternion_from_motion (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hqfm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            quat_z_o,
  output logic signed [15:0]            quat_w_o,
  output logic [1:0]                    heading_source_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQX  = 6'b000010,
    ST_SQY  = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_CORD = 6'b010000,
    ST_PUSH = 6'b100000
  } state_e;

  state_e state_q;
  logic [31:0] thr_q;
  logic first_q;
  logic signed [31:0] prev_x_q, prev_y_q;
  logic signed [15:0] pq_z_q, pq_w_q;
  hqfm_pkg::hqfm_src_e src_q;
  logic signed [31:0] dx_q, dy_q;
  logic [63:0] prod_q, sqx_q;
  logic out_valid_q;
  logic signed [15:0] out_z_q, out_w_q;
  logic [1:0] out_src_q;

  logic accept;
  logic out_free;
  logic cfg_wr;
  logic signed [31:0] dx_sat, dy_sat;
  logic [31:0] ax, ay, mul_a;
  logic [63:0] prod;
  logic [63:0] move;
  logic moving;
  logic cord_start;
  hqfm_pkg::hqfm_cordic_res_t cord_res;

  // difference with saturation to the signed 32-bit range
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = 33'(a) - 33'(b);
    if (d[32] != d[31]) begin
      r = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == hqfm_pkg::REG_IDX_MOVE_THR);
  assign prdata = (paddr[2] == hqfm_pkg::REG_IDX_MOVE_THR) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hqfm_pkg::THR_RESET;
    end else if (cfg_wr) begin
      thr_q <= pwdata;
    end
  end

  // handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared squaring multiplier
  assign dx_sat = sat_diff(pos_x_i, prev_x_q);
  assign dy_sat = sat_diff(pos_y_i, prev_y_q);
  assign ax     = dx_q[31] ? 32'(-dx_q) : 32'(dx_q);
  assign ay     = dy_q[31] ? 32'(-dy_q) : 32'(dy_q);
  assign mul_a  = (state_q == ST_SQX) ? ax : ay;
  assign prod   = 64'(mul_a) * 64'(mul_a);

  // squared length against threshold
  assign move       = sqx_q + prod_q;
  assign moving     = move > {32'b0, thr_q};
  assign cord_start = (state_q == ST_CMP) && moving;

  hqfm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .res_o   (cord_res)
  );

  // sequencer and stored state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      pq_z_q      <= hqfm_pkg::Q15_ZERO;
      pq_w_q      <= hqfm_pkg::Q15_ONE;
      src_q       <= hqfm_pkg::SRC_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      // output register: load on push, clear once taken
      if ((state_q == ST_PUSH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            prev_x_q <= pos_x_i;
            prev_y_q <= pos_y_i;
            if (first_q) begin
              first_q <= 1'b0;
              pq_z_q  <= hqfm_pkg::Q15_ZERO;
              pq_w_q  <= hqfm_pkg::Q15_ONE;
              src_q   <= hqfm_pkg::SRC_FIRST;
              state_q <= ST_PUSH;
            end else begin
              state_q <= ST_SQX;
            end
          end
        end
        ST_SQX: begin
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (moving) begin
            state_q <= ST_CORD;
          end else begin
            src_q   <= hqfm_pkg::SRC_HELD;
            state_q <= ST_PUSH;
          end
        end
        ST_CORD: begin
          if (cord_res.done) begin
            pq_z_q  <= cord_res.qz;
            pq_w_q  <= cord_res.qw;
            src_q   <= hqfm_pkg::SRC_NEW;
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= dx_sat;
      dy_q <= dy_sat;
    end
    if (state_q == ST_SQX) begin
      prod_q <= prod;
    end
    if (state_q == ST_SQY) begin
      sqx_q  <= prod_q;
      prod_q <= prod;
    end
    if ((state_q == ST_PUSH) && out_free) begin
      out_z_q   <= pq_z_q;
      out_w_q   <= pq_w_q;
      out_src_q <= src_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quat_z_o         = out_z_q;
  assign quat_w_o         = out_w_q;
  assign heading_source_o = out_src_q;

endmodule

// ===== hdl/hqfm_cordic.sv =====
// ----------------------------------------------------------------------------
// hqfm_cordic
// one shared micro-rotation unit, run first in vectoring mode for the
// heading, then in rotation mode on the half angle for sin and cos
// ----------------------------------------------------------------------------
module hqfm_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [31:0]            dx_i,
  input  logic signed [31:0]            dy_i,
  output hqfm_pkg::hqfm_cordic_res_t    res_o
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_VEC  = 4'b0010,
    PH_ROT  = 4'b0100,
    PH_FIN  = 4'b1000
  } phase_e;

  localparam logic [hqfm_pkg::ITER_W-1:0] LAST_ITER =
    hqfm_pkg::ITER_W'(hqfm_pkg::STEPS - 1);

  phase_e phase_q, phase_d;
  logic [hqfm_pkg::ITER_W-1:0] iter_q, iter_d;
  logic done_q;
  logic signed [hqfm_pkg::CW-1:0] x_q, y_q, z_q;
  logic signed [hqfm_pkg::CW-1:0] x_n, y_n, z_n;
  logic signed [hqfm_pkg::CW-1:0] xs, ys, atan_v;
  logic signed [hqfm_pkg::CW-1:0] dx_ext, dy_ext;
  logic signed [15:0] qz_q, qw_q;
  logic ccw;
  logic last;

  // round q2.30 to q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [hqfm_pkg::CW-1:0] v);
    logic signed [hqfm_pkg::CW-1:0] rnd;
    logic signed [hqfm_pkg::CW-1:0] r;
    logic signed [15:0] q;
    rnd = v + $signed(hqfm_pkg::CW'(16384));
    r   = rnd >>> 15;
    if (r > $signed(hqfm_pkg::CW'(32767))) begin
      q = 16'sd32767;
    end else if (r < -$signed(hqfm_pkg::CW'(32768))) begin
      q = -16'sd32768;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  assign dx_ext = hqfm_pkg::CW'(dx_i);
  assign dy_ext = hqfm_pkg::CW'(dy_i);

  // shared micro-rotation step
  always_comb begin
    ccw    = (phase_q == PH_VEC) ? y_q[hqfm_pkg::CW-1] : ~z_q[hqfm_pkg::CW-1];
    xs     = x_q >>> iter_q;
    ys     = y_q >>> iter_q;
    atan_v = hqfm_pkg::atan_lut(iter_q);
    x_n    = ccw ? (x_q - ys) : (x_q + ys);
    y_n    = ccw ? (y_q + xs) : (y_q - xs);
    z_n    = ccw ? (z_q - atan_v) : (z_q + atan_v);
    last   = (iter_q == LAST_ITER);
  end

  // sequencer
  always_comb begin
    phase_d = phase_q;
    iter_d  = iter_q;
    case (phase_q)
      PH_IDLE: begin
        iter_d = '0;
        if (start_i) begin
          phase_d = PH_VEC;
        end
      end
      PH_VEC: begin
        if (last) begin
          iter_d  = '0;
          phase_d = PH_ROT;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      PH_ROT: begin
        if (last) begin
          iter_d  = '0;
          phase_d = PH_FIN;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      PH_FIN: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
        iter_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      iter_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      iter_q  <= iter_d;
      done_q  <= (phase_q == PH_FIN);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          // left half plane: negate and start from plus or minus pi
          if (dx_i[31]) begin
            x_q <= -dx_ext;
            y_q <= -dy_ext;
            z_q <= dy_i[31] ? -hqfm_pkg::ANGLE_PI : hqfm_pkg::ANGLE_PI;
          end else begin
            x_q <= dx_ext;
            y_q <= dy_ext;
            z_q <= '0;
          end
        end
      end
      PH_VEC: begin
        if (last) begin
          x_q <= hqfm_pkg::INV_GAIN;
          y_q <= '0;
          z_q <= z_n >>> 1;
        end else begin
          x_q <= x_n;
          y_q <= y_n;
          z_q <= z_n;
        end
      end
      PH_ROT: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
      end
      PH_FIN: begin
        qz_q <= to_q15(y_q);
        qw_q <= to_q15(x_q);
      end
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.qz   = qz_q;
  assign res_o.qw   = qw_q;

endmodule

// ===== hdl/hqfm_checker.sv =====
// ----------------------------------------------------------------------------
// hqfm_checker
// port-level checks of the heading quaternion block, bound to the top level
// ----------------------------------------------------------------------------
`include "heading_quaternion_from_motion_assert.svh"

module hqfm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] quat_z_o,
  input logic signed [15:0] quat_w_o,
  input logic [1:0]         heading_source_o
);

  // a stalled result stays and holds its payload
  `HQFM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(quat_z_o) && $stable(quat_w_o) && $stable(heading_source_o))

  // the block is busy right after it takes a transaction
  `HQFM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // only the three defined source codes appear
  `HQFM_ASSERT_NOW(a_src_code, out_valid_o, (heading_source_o == hqfm_pkg::SRC_FIRST) || (heading_source_o == hqfm_pkg::SRC_NEW) || (heading_source_o == hqfm_pkg::SRC_HELD))

  // a first fix always answers the identity quaternion
  `HQFM_ASSERT_NOW(a_first_identity, out_valid_o && (heading_source_o == hqfm_pkg::SRC_FIRST), (quat_z_o == hqfm_pkg::Q15_ZERO) && (quat_w_o == hqfm_pkg::Q15_ONE))

endmodule

bind heading_quaternion_from_motion hqfm_checker u_hqfm_checker (.*);

// ===== verif/tb_heading_quaternion_from_motion.sv =====
// ----------------------------------------------------------------------------
// tb_heading_quaternion_from_motion
// self-checking bench for the yaw quaternion from motion block: position fixes
// go in over a valid/stall channel, every result is checked field by field
// against an in-bench cordic predictor, the threshold register is exercised
// over the apb port, and idle and stall patterns vary from phase to phase
// ----------------------------------------------------------------------------
module tb_heading_quaternion_from_motion;

  localparam int PW             = hqfm_pkg::PADDR_W;
  localparam int ROT_STEPS      = (hqfm_pkg::CORDIC_STEPS > 24) ? 24 : hqfm_pkg::CORDIC_STEPS;
  localparam int DRAIN_CYCLES   = 2 * ROT_STEPS + 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 263;

  // threshold default: 0.1 square meter with 16 fraction bits
  localparam logic [31:0] DEFAULT_THR = 32'(((64'd1 << 16) + 64'd5) / 64'd10);

  // register map
  localparam int REG_THR   = int'(hqfm_pkg::REG_IDX_MOVE_THR);
  localparam int REG_SPARE = REG_THR + 1;
  localparam logic [PW-1:0] THR_ADDR   = PW'(4 * REG_THR);
  localparam logic [PW-1:0] SPARE_ADDR = PW'(4 * REG_SPARE);

  // cordic constants, binary angles with 2^32 per turn
  localparam longint HALF_TURN     = 64'sd2147483648;
  localparam longint UNIT_GAIN_Q30 = 64'sd652032874;
  localparam logic signed [15:0] Q15_MAX = 16'sd32767;
  localparam longint ATAN_Q32 [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [15:0]    qz;
    logic signed [15:0]    qw;
    hqfm_pkg::hqfm_src_e   src;
  } quat_due_t;

  // dut signals
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PW-1:0]        paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic signed [31:0]   pos_x_i     = '0;
  logic signed [31:0]   pos_y_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [15:0]   quat_z_o;
  logic signed [15:0]   quat_w_o;
  logic [1:0]           heading_source_o;

  // predictor state
  logic [31:0]          trk_thr       = DEFAULT_THR;
  longint               trk_prev_x    = 0;
  longint               trk_prev_y    = 0;
  logic signed [15:0]   trk_qz        = '0;
  logic signed [15:0]   trk_qw        = Q15_MAX;
  logic                 first_fix_due = 1'b1;

  // bench bookkeeping
  quat_due_t            quat_due_q[$];
  quat_due_t            due_now;
  logic signed [31:0]   last_x = '0;
  logic signed [31:0]   last_y = '0;
  int                   send_idle_pct = 0;
  int                   stall_pct     = 0;
  int                   mismatch_cnt  = 0;
  int                   quiet_cycles  = 0;

  heading_quaternion_from_motion u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .quat_z_o         (quat_z_o),
    .quat_w_o         (quat_w_o),
    .heading_source_o (heading_source_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // q2.30 to q1.15, round half up then saturate
  function automatic logic signed [15:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // heading of the displacement by vectoring cordic, then sin/cos of half of it
  function automatic void yaw_quat_from_step(input longint dx, input longint dy,
                                             output logic signed [15:0] qz,
                                             output logic signed [15:0] qw);
    longint vx, vy, ang, nx;
    vx  = dx;
    vy  = dy;
    ang = 0;
    if (vx < 0) begin
      ang = (vy >= 0) ? HALF_TURN : -HALF_TURN;
      vx  = -vx;
      vy  = -vy;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (vy < 0) begin
        nx  = vx - (vy >>> i);
        vy  = vy + (vx >>> i);
        ang = ang - ATAN_Q32[i];
      end else begin
        nx  = vx + (vy >>> i);
        vy  = vy - (vx >>> i);
        ang = ang + ATAN_Q32[i];
      end
      vx = nx;
    end
    // rotate the unit vector by half the heading
    ang = ang >>> 1;
    vx  = UNIT_GAIN_Q30;
    vy  = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (ang >= 0) begin
        nx  = vx - (vy >>> i);
        vy  = vy + (vx >>> i);
        ang = ang - ATAN_Q32[i];
      end else begin
        nx  = vx + (vy >>> i);
        vy  = vy - (vx >>> i);
        ang = ang + ATAN_Q32[i];
      end
      vx = nx;
    end
    qw = round_q15(vx);
    qz = round_q15(vy);
  endfunction

  // expected quaternion for one accepted fix, updates the tracked state
  task automatic track_fix(input logic signed [31:0] x, input logic signed [31:0] y);
    quat_due_t          due;
    longint             dx, dy;
    longint unsigned    ax, ay, move;
    if (first_fix_due) begin
      first_fix_due = 1'b0;
      due.qz  = '0;
      due.qw  = Q15_MAX;
      due.src = hqfm_pkg::SRC_FIRST;
    end else begin
      dx = longint'(x) - trk_prev_x;
      dy = longint'(y) - trk_prev_y;
      if (dx > 64'sd2147483647) dx = 64'sd2147483647;
      else if (dx < -64'sd2147483648) dx = -64'sd2147483648;
      if (dy > 64'sd2147483647) dy = 64'sd2147483647;
      else if (dy < -64'sd2147483648) dy = -64'sd2147483648;
      ax   = (dx < 0) ? -dx : dx;
      ay   = (dy < 0) ? -dy : dy;
      move = ax * ax + ay * ay;
      if (move > 64'(trk_thr)) begin
        yaw_quat_from_step(dx, dy, due.qz, due.qw);
        due.src = hqfm_pkg::SRC_NEW;
      end else begin
        due.qz  = trk_qz;
        due.qw  = trk_qw;
        due.src = hqfm_pkg::SRC_HELD;
      end
    end
    trk_qz     = due.qz;
    trk_qw     = due.qw;
    trk_prev_x = longint'(x);
    trk_prev_y = longint'(y);
    quat_due_q.push_back(due);
  endtask

  // one fix transaction, with random idle cycles ahead of it
  task automatic send_fix(input logic signed [31:0] x, input logic signed [31:0] y);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_fix(x, y);
    last_x = x;
    last_y = y;
  endtask

  // fix relative to the previous one, wrapping in 32 bits
  task automatic send_step(input longint dx, input longint dy);
    send_fix(last_x + 32'(dx), last_y + 32'(dy));
  endtask

  // drop valid and wait for every expected result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (quat_due_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // apb write, setup then access
  task automatic write_reg(input logic [PW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (int'(addr >> 2) == REG_THR) trk_thr = data;
  endtask

  // apb read of the threshold, compared with the tracked value
  task automatic check_thr_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= THR_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== trk_thr) begin
      $display("%0t: threshold readback expected %0d got %0d", $time, trk_thr, prdata);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quat_due_q.size() == 0) begin
        $display("%0t: result with nothing expected: z %0d w %0d source %0d",
                 $time, quat_z_o, quat_w_o, heading_source_o);
        mismatch_cnt++;
      end else begin
        due_now = quat_due_q.pop_front();
        if (quat_z_o !== due_now.qz) begin
          $display("%0t: quat_z expected %0d got %0d", $time, due_now.qz, quat_z_o);
          mismatch_cnt++;
        end
        if (quat_w_o !== due_now.qw) begin
          $display("%0t: quat_w expected %0d got %0d", $time, due_now.qw, quat_w_o);
          mismatch_cnt++;
        end
        if (heading_source_o !== due_now.src) begin
          $display("%0t: heading_source expected %0d got %0d",
                   $time, due_now.src, heading_source_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("tb_heading_quaternion_from_motion: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // reset value, first fix, every quadrant, half turn and saturated jumps
  task automatic test_first_fix_and_headings();
    check_thr_readback();
    send_fix(32'sh7fffffff, 32'sh80000000);
    send_fix(32'sh80000000, 32'sh7fffffff);
    send_fix(32'sh80000000, 32'sh7fffffff);
    send_fix(32'sh00000000, 32'sh00000000);
    // default threshold sits between 80^2 and 81^2
    send_step(80, 0);
    send_step(81, 0);
    send_step(0, 300);
    send_step(-300, 0);
    send_step(0, -300);
    send_step(-300, -300);
    send_step(300, -300);
    send_step(-300, 300);
    send_step(1, 1);
    send_fix(32'sh7fffffff, 32'sh7fffffff);
    send_fix(32'sh80000000, 32'sh80000000);
    send_fix(32'sh80000000, 32'sh7fffffff);
    settle();
  endtask

  // threshold extremes, equality boundary and writes to an unused index
  task automatic test_threshold_edges();
    write_reg(THR_ADDR, 32'd0);
    check_thr_readback();
    send_step(0, 0);
    send_step(1, 0);
    send_step(0, -1);
    settle();
    write_reg(THR_ADDR, 32'd10000);
    check_thr_readback();
    send_step(100, 0);
    send_step(-100, 1);
    settle();
    write_reg(THR_ADDR, 32'hffffffff);
    check_thr_readback();
    send_step(65535, 0);
    send_step(0, -65536);
    settle();
    write_reg(SPARE_ADDR, 32'd12345);
    check_thr_readback();
    send_step(-65535, 0);
    settle();
    write_reg(THR_ADDR, DEFAULT_THR);
    check_thr_readback();
  endtask

  // random walks with varied step sizes across idle and stall phases
  task automatic test_random_motion();
    int                 pick;
    int                 span;
    longint             dx, dy, root;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          write_reg(THR_ADDR, DEFAULT_THR);
        end
        1: begin
          send_idle_pct = 55;
          stall_pct     = 0;
          write_reg(THR_ADDR, $urandom_range(0, 200000));
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 55;
          write_reg(THR_ADDR, 32'd0);
        end
        default: begin
          send_idle_pct = 20;
          stall_pct     = 20;
          write_reg(THR_ADDR, $urandom());
        end
      endcase
      check_thr_readback();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        dx   = 0;
        dy   = 0;
        if (pick < 10) begin
          // standing still
          send_step(0, 0);
        end else if (pick < 25) begin
          // anywhere in the full range
          send_fix($urandom(), $urandom());
        end else if (pick < 40) begin
          // right around the threshold, along one axis
          root = longint'($floor($sqrt(real'(trk_thr))));
          dx   = root + longint'($urandom_range(2)) - 1;
          if ($urandom_range(1)) dx = -dx;
          if ($urandom_range(1)) send_step(dx, 0);
          else send_step(0, dx);
        end else if (pick < 55) begin
          // pure axis moves, including the half turn
          dx = longint'($urandom_range(1, 4000));
          case ($urandom_range(3))
            0: send_step(dx, 0);
            1: send_step(-dx, 0);
            2: send_step(0, dx);
            default: send_step(0, -dx);
          endcase
        end else begin
          span = 1 << $urandom_range(2, 24);
          dx   = longint'($urandom_range(0, 2 * span)) - span;
          dy   = longint'($urandom_range(0, 2 * span)) - span;
          send_step(dx, dy);
        end
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_fix_and_headings();
    test_threshold_edges();
    test_random_motion();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && quat_due_q.size() == 0) begin
      $display("tb_heading_quaternion_from_motion: done, clean");
    end else begin
      $display("tb_heading_quaternion_from_motion: done, errors");
    end
    $finish;
  end

endmodule
